// ===== rtl/core/fcrq_pkg.sv =====
// ----------------------------------------------------------------------------
// fcrq_pkg
// Shared types and constants of the int8 fully connected requantizing layer:
// channel payloads, configuration registers and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package fcrq_pkg;

  localparam int MAX_COLS_DEFAULT = 1024;
  localparam int QUEUE_DEPTH      = 4;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 32;

  // Columns are carried on a 10-bit field, so a row is never longer than this.
  localparam logic [10:0] COL_LIMIT = 11'd1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INPUT_OFFSET   = 3'd0,
    REG_OUTPUT_OFFSET  = 3'd1,
    REG_OUT_MULTIPLIER = 3'd2,
    REG_OUT_SHIFT      = 3'd3,
    REG_NUM_COLS       = 3'd4,
    REG_NUM_ROWS       = 3'd5,
    REG_ACT_MIN        = 3'd6,
    REG_ACT_MAX        = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    ACT_STORE  = 1'b0,
    ACT_WEIGHT = 1'b1
  } action_t;

  typedef struct packed {
    logic               action;
    logic [9:0]         col_index;
    logic signed [7:0]  value;
    logic signed [31:0] bias;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] result;
    logic [15:0]       row_index;
    logic              last_row;
  } out_item_t;

  typedef struct packed {
    logic signed [8:0]  input_offset;
    logic signed [7:0]  output_offset;
    logic signed [31:0] out_multiplier;
    logic signed [5:0]  out_shift;
    logic [10:0]        num_cols;
    logic [15:0]        num_rows;
    logic signed [7:0]  act_min;
    logic signed [7:0]  act_max;
  } cfg_t;

  // One weight beat, classified and with its activation already fetched.
  typedef struct packed {
    logic               first_col;
    logic               last_col;
    logic signed [31:0] bias;
    logic signed [7:0]  act;
    logic signed [7:0]  weight;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t data;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/fcrq_front.sv =====
// ----------------------------------------------------------------------------
// fcrq_front
// Accepts input beats. Store beats write the activation memory; weight beats
// read it, get tagged as first/last column and are handed to the queue.
// ----------------------------------------------------------------------------
module fcrq_front import fcrq_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item_data,
  input  logic [10:0] num_cols,
  input  q_status_t q_status,
  output q_push_t   q_push
);

  localparam int AW = $clog2(MAX_COLS);

  logic [7:0]         mem [MAX_COLS];
  logic [7:0]         rd_act;
  logic               s1_valid;
  logic               s1_act_ok;
  logic               s1_first;
  logic               s1_last;
  logic signed [31:0] s1_bias;
  logic signed [7:0]  s1_weight;

  logic          accept;
  logic          push;
  logic          col_ok;
  logic [AW-1:0] addr;
  logic [9:0]    last_col;

  assign col_ok = 32'(item_data.col_index) < 32'(MAX_COLS);
  assign addr   = AW'(item_data.col_index);

  always_comb begin
    if (num_cols == 11'd0) begin
      last_col = 10'd0;
    end else if (num_cols > COL_LIMIT) begin
      last_col = 10'(COL_LIMIT - 11'd1);
    end else begin
      last_col = 10'(num_cols - 11'd1);
    end
  end

  assign push       = s1_valid && !q_status.full;
  assign item_stall = s1_valid && q_status.full;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (accept && item_data.action == ACT_STORE && col_ok) begin
      mem[addr] <= item_data.value;
    end
    if (accept && item_data.action == ACT_WEIGHT) begin
      rd_act <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item_data.action == ACT_WEIGHT) begin
      s1_act_ok <= col_ok;
      s1_first  <= item_data.col_index == 10'd0;
      s1_last   <= item_data.col_index == last_col;
      s1_bias   <= item_data.bias;
      s1_weight <= item_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && item_data.action == ACT_WEIGHT) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    q_push.push           = push;
    q_push.data.first_col = s1_first;
    q_push.data.last_col  = s1_last;
    q_push.data.bias      = s1_bias;
    // Columns outside the store read as zero
    q_push.data.act       = s1_act_ok ? rd_act : 8'sd0;
    q_push.data.weight    = s1_weight;
  end

endmodule

// ===== rtl/core/fcrq_queue.sv =====
// ----------------------------------------------------------------------------
// fcrq_queue
// Short FIFO of classified weight beats between the front and the back.
// ----------------------------------------------------------------------------
module fcrq_queue import fcrq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_push_t   q_push,
  input  logic      pop,
  output q_entry_t  pop_data,
  output q_status_t q_status
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t      slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign q_status.full  = count == CW'(QUEUE_DEPTH);
  assign q_status.empty = count == '0;
  assign do_push        = q_push.push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_data       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/fcrq_back.sv =====
// ----------------------------------------------------------------------------
// fcrq_back
// Multiply-accumulate of queued weight beats and, at the last column, the
// requantize sequence: shift left, rounding high multiply, rounding shift
// right, output offset and clamp, into the result register.
// ----------------------------------------------------------------------------
module fcrq_back import fcrq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  q_status_t q_status,
  input  q_entry_t  pop_data,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result_data
);

  typedef enum logic [2:0] {
    S_MAC,
    S_LSH,
    S_MUL,
    S_HIGH,
    S_RSH,
    S_OUT
  } state_t;

  state_t             state;
  logic signed [31:0] acc;
  logic signed [31:0] a_reg;
  logic signed [63:0] p_reg;
  logic signed [31:0] hi_reg;
  logic signed [32:0] sh_reg;
  logic [15:0]        row_cnt;

  logic signed [9:0]  lhs;
  logic signed [17:0] prod;
  logic signed [31:0] acc_next;
  logic [4:0]         ls;
  logic [4:0]         rs;
  logic [5:0]         neg_shift;
  logic signed [63:0] rnd;
  logic signed [32:0] hi33;
  logic signed [32:0] half;
  logic signed [32:0] rsum;
  logic signed [33:0] clamped;
  logic [15:0]        nrows;
  logic               is_last_row;
  logic               out_free;

  assign pop      = state == S_MAC && !q_status.empty;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    lhs      = 10'(pop_data.act) + 10'(cfg.input_offset);
    prod     = lhs * pop_data.weight;
    acc_next = (pop_data.first_col ? pop_data.bias : acc) + 32'(prod);
  end

  always_comb begin
    neg_shift = 6'd0 - cfg.out_shift;
    ls = (cfg.out_shift > 6'sd0) ? cfg.out_shift[4:0] : 5'd0;
    // A shift of -32 wraps to no shift
    rs = (cfg.out_shift < 6'sd0) ? neg_shift[4:0] : 5'd0;
  end

  always_comb begin
    rnd  = p_reg + 64'sd1073741824;
    hi33 = rnd[63:31];
    half = (rs == 5'd0) ? 33'sd0 : (33'sd1 <<< (rs - 5'd1));
    rsum = 33'(hi_reg) + half;
  end

  always_comb begin
    clamped = 34'(sh_reg) + 34'(cfg.output_offset);
    if (clamped < 34'(cfg.act_min)) begin
      clamped = 34'(cfg.act_min);
    end
    if (clamped > 34'(cfg.act_max)) begin
      clamped = 34'(cfg.act_max);
    end
  end

  assign nrows       = (cfg.num_rows == 16'd0) ? 16'd1 : cfg.num_rows;
  assign is_last_row = (17'(row_cnt) + 17'd1) >= 17'(nrows);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_MAC;
      acc          <= '0;
      row_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_MAC: begin
          if (pop) begin
            acc <= acc_next;
            if (pop_data.last_col) begin
              state <= S_LSH;
            end
          end
        end
        S_LSH: begin
          a_reg <= acc << ls;
          state <= S_MUL;
        end
        S_MUL: begin
          p_reg <= a_reg * cfg.out_multiplier;
          state <= S_HIGH;
        end
        S_HIGH: begin
          // Only the product of two most negative values overflows upward
          hi_reg <= (!hi33[32] && hi33[31]) ? 32'sh7FFF_FFFF : hi33[31:0];
          state  <= S_RSH;
        end
        S_RSH: begin
          sh_reg <= rsum >>> rs;
          state  <= S_OUT;
        end
        S_OUT: begin
          // Hold until the result register frees up
          if (out_free) begin
            result_data.result    <= clamped[7:0];
            result_data.row_index <= row_cnt;
            result_data.last_row  <= is_last_row;
            row_cnt               <= is_last_row ? 16'd0 : row_cnt + 16'd1;
            state                 <= S_MAC;
          end
        end
        default: begin
          state <= S_MAC;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/int8_fully_connected_requant_top.sv =====
// ----------------------------------------------------------------------------
// int8_fully_connected_requant_top
// Int8 vector-times-matrix row engine with requantization to int8.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload       Beat moves when
//  item      item_valid / item_stall   item_data     item_valid & !item_stall
//  result    result_valid/result_stall result_data   result_valid & !result_stall
//  config    cfg_write                 cfg_index,    cfg_write
//                                      cfg_data
//
//  Weight beats stream at one per cycle, while the queue has room, through
//  the single accumulator in the back end. A weight at the last column adds
//  the requantize steps (shift, 32x32 multiply, round, shift, clamp), during
//  which the queue fills and then stalls the item side. Reset clears the
//  accumulator and row counter and sets the config registers to defaults;
//  activation memory is not cleared. A stalled result holds the back end in
//  its final step while later weight beats keep filling the queue.
//
module int8_fully_connected_requant_top import fcrq_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  in_item_t               item_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output out_item_t              result_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  q_push_t   q_push;
  q_status_t q_status;
  q_entry_t  pop_data;
  logic      pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_offset   <= '0;
      cfg.output_offset  <= '0;
      cfg.out_multiplier <= 32'sh4000_0000;
      cfg.out_shift      <= '0;
      cfg.num_cols       <= 11'd1;
      cfg.num_rows       <= 16'd1;
      cfg.act_min        <= 8'sh80;
      cfg.act_max        <= 8'sh7F;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_INPUT_OFFSET:   cfg.input_offset   <= cfg_data[8:0];
        REG_OUTPUT_OFFSET:  cfg.output_offset  <= cfg_data[7:0];
        REG_OUT_MULTIPLIER: cfg.out_multiplier <= cfg_data[31:0];
        REG_OUT_SHIFT:      cfg.out_shift      <= cfg_data[5:0];
        REG_NUM_COLS:       cfg.num_cols       <= cfg_data[10:0];
        REG_NUM_ROWS:       cfg.num_rows       <= cfg_data[15:0];
        REG_ACT_MIN:        cfg.act_min        <= cfg_data[7:0];
        REG_ACT_MAX:        cfg.act_max        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  fcrq_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_data  (item_data),
    .num_cols   (cfg.num_cols),
    .q_status   (q_status),
    .q_push     (q_push)
  );

  fcrq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .pop      (pop),
    .pop_data (pop_data),
    .q_status (q_status)
  );

  fcrq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_status     (q_status),
    .pop_data     (pop_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

// ===== rtl/core/fcrq_checker.sv =====
// ----------------------------------------------------------------------------
// fcrq_checker
// Port-level checks of the fully connected requantizing layer, bound to the
// top level.
// ----------------------------------------------------------------------------
module fcrq_checker import fcrq_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result_data
);

  logic [15:0] exp_row;

  // Track the row number the next result beat must carry
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_row <= '0;
    end else if (result_valid && !result_stall) begin
      exp_row <= result_data.last_row ? 16'd0 : result_data.row_index + 16'd1;
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("stalled result beat changed or dropped");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat present right after reset");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.row_index == exp_row)
    else $error("result row out of sequence");

endmodule

bind int8_fully_connected_requant_top fcrq_checker u_fcrq_checker (.*);
